FILE: rtl/core/cmkp_pkg.sv
// ----------------------------------------------------------------------------
// cmkp_pkg
// Shared constants, types and the key table for the certificate key check.
// ----------------------------------------------------------------------------
`default_nettype none

package cmkp_pkg;

   localparam int NEST_DEPTH = 16;
   localparam int LEN_BITS   = 32;

   localparam int ACC_W = 32;
   localparam int CNT_W = LEN_BITS + 1;
   localparam int LVL_W = $clog2(NEST_DEPTH + 1);
   localparam int STK_AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

   localparam logic [3:0] KEY_LEN = 4'd11;

   localparam logic [7:0] TAG_BYTE0 = 8'hD9;
   localparam logic [7:0] TAG_BYTE2 = 8'hF7;

   localparam logic [2:0] MAJ_UINT  = 3'd0;
   localparam logic [2:0] MAJ_NINT  = 3'd1;
   localparam logic [2:0] MAJ_BSTR  = 3'd2;
   localparam logic [2:0] MAJ_TSTR  = 3'd3;
   localparam logic [2:0] MAJ_MAP   = 3'd5;
   localparam logic [2:0] MAJ_SIMPLE = 3'd7;

   localparam logic [4:0] AI_ONE_BYTE = 5'd24;
   localparam logic [4:0] AI_FIRST_BAD = 5'd27;
   localparam logic [LEN_BITS-1:0] SIMPLE_NULL_OK = LEN_BITS'(22);

   typedef enum logic [2:0] {
      VERDICT_FOUND     = 3'd0,
      VERDICT_EMPTY     = 3'd1,
      VERDICT_NOT_FOUND = 3'd2,
      VERDICT_MALFORMED = 3'd3,
      VERDICT_TRUNCATED = 3'd4,
      VERDICT_TOO_DEEP  = 3'd5
   } verdict_type;

   typedef struct packed {
      logic             clear;
      logic             set_one;
      logic             advance;
      logic [CNT_W-1:0] push_count;
   } stack_req_type;

   typedef struct packed {
      logic empty;
      logic too_deep;
   } stack_status_type;

   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h63;
         4'd1:    ch = 8'h65;
         4'd2:    ch = 8'h72;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h69;
         4'd5:    ch = 8'h66;
         4'd6:    ch = 8'h69;
         4'd7:    ch = 8'h63;
         4'd8:    ch = 8'h61;
         4'd9:    ch = 8'h74;
         4'd10:   ch = 8'h65;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbor_map_key_presence_check.sv
// ----------------------------------------------------------------------------
// cbor_map_key_presence_check
// Streams a CBOR buffer and reports whether the top-level map holds a
// nonempty "certificate" byte string.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the buffer one word per handshake on req_ (data byte plus a final
//   flag on the last byte). Exactly one word leaves on rsp_ per buffer, for
//   the byte marked final: a verdict code and a field_present flag.
//   Throughput is one byte per cycle; each byte updates the parse counters
//   and the skip-stack top in a single step, the lower stack levels live in
//   a registered-read RAM whose read is forwarded around a same-cycle write.
//   The registered verdict appears in the cycle after the final byte is
//   taken. It waits in the output register while rsp_ready is low, and
//   req_ready stays low with it, so no byte is taken until the waiting word
//   leaves; a new byte is taken in the same cycle the waiting word leaves.
//   Reset (synchronous) empties the output and starts a fresh buffer; the
//   block also returns to its start state after every final byte. There is
//   no clearing pass: stack levels are written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module cbor_map_key_presence_check (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [2:0] rsp_verdict,
   output      logic       rsp_field_present
);

   localparam int LB = cmkp_pkg::LEN_BITS;
   localparam int AC = cmkp_pkg::ACC_W;

   typedef enum logic [3:0] {
      PH_START, PH_PRE1, PH_PRE2, PH_TOP_HDR, PH_TOP_ARG, PH_KEY_HDR,
      PH_KEY_ARG, PH_KEY_TXT, PH_CERT_HDR, PH_CERT_ARG, PH_CERT_BODY,
      PH_SKIP_HDR, PH_SKIP_ARG_STR, PH_SKIP_ARG_MAP, PH_SKIP_ARG_SIMPLE,
      PH_SKIP_STR
   } phase_type;

   phase_type   phase_ff, phase_a, phase_in, kind, hctx;
   logic [2:0]  argl_ff, argl_in;
   logic [AC-1:0] acc_ff, acc_in, acc_sh;
   logic [LB-1:0] pairs_ff, pairs_a, pairs_in, pairs_dec, dn;
   logic [3:0]  kpos_ff, kpos_in;
   logic        kmatch_ff, kmatch_in;
   cmkp_pkg::verdict_type vdec_ff, vdec_a, vdec_in, rsp_v;
   logic        vvalid_ff, vvalid_a, vvalid_in;
   logic        rsp_valid_ff;
   cmkp_pkg::verdict_type rsp_verdict_ff;
   logic        rsp_present_ff;

   logic        go, step, hdr_on, dlv, key_end, kind_ok;
   logic [2:0]  major;
   logic [4:0]  ai;
   logic [1:0]  ai_sh;

   cmkp_pkg::stack_req_type    stk_req;
   cmkp_pkg::stack_status_type stk_st;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign go        = req_valid && req_ready;
   assign step      = go && !vvalid_ff;
   assign major     = req_data_byte[7:5];
   assign ai        = req_data_byte[4:0];
   assign ai_sh     = ai[1:0] - 2'd0;

   // byte-level parse; stack advances are resolved afterwards
   always_comb begin
      phase_a   = phase_ff;
      argl_in   = argl_ff;
      acc_in    = acc_ff;
      pairs_a   = pairs_ff;
      kpos_in   = kpos_ff;
      kmatch_in = kmatch_ff;
      vdec_a    = vdec_ff;
      vvalid_a  = vvalid_ff;
      stk_req   = '0;
      hdr_on    = 1'b0;
      hctx      = phase_ff;
      dlv       = 1'b0;
      kind      = phase_ff;
      kind_ok   = 1'b0;
      dn        = '0;
      key_end   = 1'b0;
      acc_sh    = {acc_ff[AC-9:0], req_data_byte};
      stk_req.clear = go && req_final_byte;
      if (step) begin
         case (phase_ff)
            PH_START: begin
               if (req_data_byte == cmkp_pkg::TAG_BYTE0) begin
                  phase_a = PH_PRE1;
               end else begin
                  hdr_on = 1'b1;
                  hctx   = PH_TOP_HDR;
               end
            end
            PH_PRE1: begin
               argl_in = (req_data_byte == cmkp_pkg::TAG_BYTE0) ? 3'd0 : 3'd1;
               phase_a = PH_PRE2;
            end
            PH_PRE2: begin
               if (argl_ff == 3'd0 && req_data_byte == cmkp_pkg::TAG_BYTE2) begin
                  phase_a = PH_TOP_HDR;
               end else begin
                  vdec_a   = cmkp_pkg::VERDICT_MALFORMED;
                  vvalid_a = 1'b1;
               end
               argl_in = 3'd0;
            end
            PH_TOP_HDR, PH_KEY_HDR, PH_CERT_HDR, PH_SKIP_HDR: begin
               hdr_on = 1'b1;
            end
            PH_TOP_ARG, PH_KEY_ARG, PH_CERT_ARG, PH_SKIP_ARG_STR,
            PH_SKIP_ARG_MAP, PH_SKIP_ARG_SIMPLE: begin
               acc_in = acc_sh;
               if (argl_ff != 3'd0) begin
                  argl_in = argl_ff - 3'd1;
               end
               if (argl_in == 3'd0) begin
                  dlv  = 1'b1;
                  kind = phase_ff;
                  // saturate lengths wider than LB bits (only when ACC_W exceeds LEN_BITS)
                  if (LB < AC && (acc_sh >> LB) != '0) begin
                     dn = '1;
                  end else begin
                     dn = acc_sh[LB-1:0];
                  end
               end
            end
            PH_KEY_TXT: begin
               if (kpos_ff >= cmkp_pkg::KEY_LEN
                   || req_data_byte != cmkp_pkg::key_char(kpos_ff)) begin
                  kmatch_in = 1'b0;
               end
               if (kpos_ff < cmkp_pkg::KEY_LEN) begin
                  kpos_in = kpos_ff + 4'd1;
               end
               acc_in = acc_ff - AC'(1);
               key_end = (acc_in == '0);
            end
            PH_CERT_BODY: begin
               acc_in = acc_ff - AC'(1);
               if (acc_in == '0) begin
                  vdec_a   = cmkp_pkg::VERDICT_FOUND;
                  vvalid_a = 1'b1;
               end
            end
            default: begin
               acc_in = acc_ff - AC'(1);
               if (acc_in == '0) begin
                  stk_req.advance = 1'b1;
               end
            end
         endcase

         if (hdr_on) begin
            if (ai >= cmkp_pkg::AI_FIRST_BAD) begin
               vdec_a   = cmkp_pkg::VERDICT_MALFORMED;
               vvalid_a = 1'b1;
            end else begin
               case (hctx)
                  PH_TOP_HDR: begin
                     kind_ok = (major == cmkp_pkg::MAJ_MAP);
                     kind    = PH_TOP_ARG;
                  end
                  PH_KEY_HDR: begin
                     kind_ok = (major == cmkp_pkg::MAJ_TSTR);
                     kind    = PH_KEY_ARG;
                  end
                  PH_CERT_HDR: begin
                     kind_ok = (major == cmkp_pkg::MAJ_BSTR);
                     kind    = PH_CERT_ARG;
                  end
                  default: begin
                     kind_ok = 1'b1;
                     if (major == cmkp_pkg::MAJ_BSTR || major == cmkp_pkg::MAJ_TSTR) begin
                        kind = PH_SKIP_ARG_STR;
                     end else if (major == cmkp_pkg::MAJ_MAP) begin
                        kind = PH_SKIP_ARG_MAP;
                     end else if (major == cmkp_pkg::MAJ_SIMPLE) begin
                        kind = PH_SKIP_ARG_SIMPLE;
                     end else if (major == cmkp_pkg::MAJ_UINT
                                  || major == cmkp_pkg::MAJ_NINT) begin
                        // integers: skip the argument bytes like a string body
                        kind_ok = 1'b0;
                        if (ai < cmkp_pkg::AI_ONE_BYTE) begin
                           stk_req.advance = 1'b1;
                        end else begin
                           acc_in  = AC'(1) << ai_sh;
                           phase_a = PH_SKIP_STR;
                        end
                     end else begin
                        kind_ok  = 1'b0;
                        vdec_a   = cmkp_pkg::VERDICT_MALFORMED;
                        vvalid_a = 1'b1;
                     end
                  end
               endcase
               if (!kind_ok && (hctx == PH_TOP_HDR || hctx == PH_KEY_HDR
                                || hctx == PH_CERT_HDR)) begin
                  vdec_a   = cmkp_pkg::VERDICT_MALFORMED;
                  vvalid_a = 1'b1;
               end
               if (kind_ok) begin
                  if (ai < cmkp_pkg::AI_ONE_BYTE) begin
                     dlv = 1'b1;
                     dn  = LB'(ai);
                  end else begin
                     argl_in = 3'd1 << ai_sh;
                     acc_in  = '0;
                     phase_a = kind;
                  end
               end
            end
         end

         if (dlv) begin
            case (kind)
               PH_TOP_ARG: begin
                  if (dn == '0) begin
                     vdec_a   = cmkp_pkg::VERDICT_NOT_FOUND;
                     vvalid_a = 1'b1;
                  end else begin
                     pairs_a = dn;
                     phase_a = PH_KEY_HDR;
                  end
               end
               PH_KEY_ARG: begin
                  kpos_in   = 4'd0;
                  kmatch_in = (dn == LB'(cmkp_pkg::KEY_LEN));
                  if (dn == '0) begin
                     key_end = 1'b1;
                  end else begin
                     acc_in  = AC'(dn);
                     phase_a = PH_KEY_TXT;
                  end
               end
               PH_CERT_ARG: begin
                  if (dn == '0) begin
                     vdec_a   = cmkp_pkg::VERDICT_EMPTY;
                     vvalid_a = 1'b1;
                  end else begin
                     acc_in  = AC'(dn);
                     phase_a = PH_CERT_BODY;
                  end
               end
               PH_SKIP_ARG_STR: begin
                  if (dn == '0) begin
                     stk_req.advance = 1'b1;
                  end else begin
                     acc_in  = AC'(dn);
                     phase_a = PH_SKIP_STR;
                  end
               end
               PH_SKIP_ARG_MAP: begin
                  stk_req.advance    = 1'b1;
                  stk_req.push_count = {dn, 1'b0};
               end
               default: begin
                  if (dn == cmkp_pkg::SIMPLE_NULL_OK) begin
                     stk_req.advance = 1'b1;
                  end else begin
                     vdec_a   = cmkp_pkg::VERDICT_MALFORMED;
                     vvalid_a = 1'b1;
                  end
               end
            endcase
         end

         if (key_end) begin
            if (kmatch_in) begin
               phase_a = PH_CERT_HDR;
            end else begin
               stk_req.set_one = 1'b1;
               phase_a = PH_SKIP_HDR;
            end
         end
      end
   end

   cmkp_stack u_stack (
      .clock (clock),
      .reset (reset),
      .req   (stk_req),
      .status(stk_st)
   );

   // resolve a finished skipped item
   always_comb begin
      phase_in  = phase_a;
      pairs_in  = pairs_a;
      vdec_in   = vdec_a;
      vvalid_in = vvalid_a;
      pairs_dec = (pairs_a != '0) ? pairs_a - LB'(1) : pairs_a;
      if (stk_req.advance) begin
         if (stk_st.too_deep) begin
            vdec_in   = cmkp_pkg::VERDICT_TOO_DEEP;
            vvalid_in = 1'b1;
         end else if (stk_st.empty) begin
            pairs_in = pairs_dec;
            if (pairs_dec == '0) begin
               vdec_in   = cmkp_pkg::VERDICT_NOT_FOUND;
               vvalid_in = 1'b1;
            end else begin
               phase_in = PH_KEY_HDR;
            end
         end else begin
            phase_in = PH_SKIP_HDR;
         end
      end
      rsp_v = vvalid_in ? vdec_in : cmkp_pkg::VERDICT_TRUNCATED;
   end

   always_ff @(posedge clock) begin
      if (reset || (go && req_final_byte)) begin
         phase_ff  <= PH_START;
         argl_ff   <= 3'd0;
         acc_ff    <= '0;
         pairs_ff  <= '0;
         kpos_ff   <= 4'd0;
         kmatch_ff <= 1'b1;
         vdec_ff   <= cmkp_pkg::VERDICT_FOUND;
         vvalid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         argl_ff   <= argl_in;
         acc_ff    <= acc_in;
         pairs_ff  <= pairs_in;
         kpos_ff   <= kpos_in;
         kmatch_ff <= kmatch_in;
         vdec_ff   <= vdec_in;
         vvalid_ff <= vvalid_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && req_final_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (go && req_final_byte) begin
         rsp_verdict_ff <= rsp_v;
         rsp_present_ff <= (rsp_v == cmkp_pkg::VERDICT_FOUND);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_field_present = rsp_present_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cmkp_ram.sv
// ----------------------------------------------------------------------------
// cmkp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cmkp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/cmkp_stack.sv
// ----------------------------------------------------------------------------
// cmkp_stack
// Skip-item count stack: top count in a register, lower levels in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module cmkp_stack (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmkp_pkg::stack_req_type    req,
   output      cmkp_pkg::stack_status_type status
);

   localparam int CW = cmkp_pkg::CNT_W;
   localparam int LW = cmkp_pkg::LVL_W;
   localparam int AW = cmkp_pkg::STK_AW;

   logic [LW-1:0] level_ff, level_in;
   logic [CW-1:0] top_ff, top_in;
   logic          fwd_ff, fwd_in;
   logic [CW-1:0] fwd_data_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] rd_data;
   logic [CW-1:0] below;
   logic [LW-1:0] lvl_tmp;

   // entry just under the top; a RAM read does not see a write to its address in the same cycle
   assign below = fwd_ff ? fwd_data_ff : rd_data;

   always_comb begin
      level_in = level_ff;
      top_in   = top_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = top_ff;
      status.too_deep = 1'b0;
      if (req.advance) begin
         if (level_in != '0 && top_in != '0) begin
            top_in = top_in - CW'(1);
         end
         if (level_in != '0 && top_in == '0) begin
            level_in = level_in - LW'(1);
            top_in   = below;
         end
         if (req.push_count != '0) begin
            if (level_in >= LW'(cmkp_pkg::NEST_DEPTH)) begin
               status.too_deep = 1'b1;
            end else begin
               if (level_in != '0) begin
                  lvl_tmp = level_in - LW'(1);
                  wr_en   = 1'b1;
                  wr_addr = lvl_tmp[AW-1:0];
                  wr_data = top_in;
               end
               top_in   = req.push_count;
               level_in = level_in + LW'(1);
            end
         end
      end
      status.empty = (level_in == '0);
      if (req.set_one) begin
         level_in = LW'(1);
         top_in   = CW'(1);
      end
      if (req.clear) begin
         level_in = '0;
      end
      lvl_tmp = level_in - LW'(2);
      rd_addr = lvl_tmp[AW-1:0];
      fwd_in  = wr_en && (wr_addr == rd_addr);
   end

   cmkp_ram #(
      .WIDTH(CW),
      .DEPTH(cmkp_pkg::NEST_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         level_ff <= level_in;
         fwd_ff   <= fwd_in;
      end
      top_ff      <= top_in;
      fwd_data_ff <= wr_data;
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams CBOR buffers into cbor_map_key_presence_check and checks every
// verdict word against a byte-level predictor of the certificate key parse.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam int NDEPTH = cmkp_pkg::NEST_DEPTH;
   localparam logic [3:0] PH_START = 4'd0, PH_PRE1 = 4'd1, PH_PRE2 = 4'd2,
      PH_TOP_HDR = 4'd3, PH_TOP_ARG = 4'd4, PH_KEY_HDR = 4'd5, PH_KEY_ARG = 4'd6,
      PH_KEY_TXT = 4'd7, PH_CERT_HDR = 4'd8, PH_CERT_ARG = 4'd9,
      PH_CERT_BODY = 4'd10, PH_SKIP_HDR = 4'd11, PH_SKIP_ARG_STR = 4'd12,
      PH_SKIP_ARG_MAP = 4'd13, PH_SKIP_ARG_SIMPLE = 4'd14, PH_SKIP_STR = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic req_final_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_verdict;
   logic rsp_field_present;

   cbor_map_key_presence_check DUT (.*);

   always #1 clock = ~clock;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_word_t;

   typedef struct packed {
      cmkp_pkg::verdict_type verdict;
      logic                  present;
   } verdict_word_t;

   byte_word_t    pending_bytes[$];
   verdict_word_t expected_verdicts[$];
   int            mismatches = 0;
   bit            stim_done = 1'b0;
   int            hold_off = 0;

   // predictor state
   logic [3:0]  ph;
   logic [2:0]  argn;
   logic [31:0] acc;
   logic [31:0] pairs;
   logic [63:0] stk[NDEPTH];
   int          lvl;
   logic [3:0]  kpos;
   logic        kmatch;
   cmkp_pkg::verdict_type dec;
   logic        decided;

   function automatic logic [7:0] cert_char(int i);
      string s;
      s = "certificate";
      return s[i];
   endfunction

   function automatic void pred_clear();
      ph = PH_START; argn = 0; acc = 0; pairs = 0; lvl = 0;
      kpos = 0; kmatch = 1'b1; dec = cmkp_pkg::VERDICT_FOUND; decided = 1'b0;
      for (int i = 0; i < NDEPTH; i++) stk[i] = 0;
   endfunction

   function automatic void settle(cmkp_pkg::verdict_type v);
      dec = v;
      decided = 1'b1;
   endfunction

   function automatic void finish_pair();
      if (pairs > 0) pairs--;
      if (pairs == 0) settle(cmkp_pkg::VERDICT_NOT_FOUND);
      else ph = PH_KEY_HDR;
   endfunction

   function automatic void skip_step(logic [63:0] push);
      if (lvl > 0 && stk[lvl-1] > 0) stk[lvl-1]--;
      while (lvl > 0 && stk[lvl-1] == 0) lvl--;
      if (push > 0) begin
         if (lvl >= NDEPTH) begin
            settle(cmkp_pkg::VERDICT_TOO_DEEP);
            return;
         end
         stk[lvl] = push;
         lvl++;
      end
      if (lvl == 0) finish_pair();
      else ph = PH_SKIP_HDR;
   endfunction

   function automatic void key_end();
      if (kmatch) ph = PH_CERT_HDR;
      else begin
         stk[0] = 1; lvl = 1; ph = PH_SKIP_HDR;
      end
   endfunction

   function automatic void arg_done(logic [3:0] kind, logic [31:0] n);
      case (kind)
         PH_TOP_ARG: begin
            if (n == 0) settle(cmkp_pkg::VERDICT_NOT_FOUND);
            else begin pairs = n; ph = PH_KEY_HDR; end
         end
         PH_KEY_ARG: begin
            kpos = 0;
            kmatch = (n == 11);
            if (n == 0) key_end();
            else begin acc = n; ph = PH_KEY_TXT; end
         end
         PH_CERT_ARG: begin
            if (n == 0) settle(cmkp_pkg::VERDICT_EMPTY);
            else begin acc = n; ph = PH_CERT_BODY; end
         end
         PH_SKIP_ARG_STR: begin
            if (n == 0) skip_step(0);
            else begin acc = n; ph = PH_SKIP_STR; end
         end
         PH_SKIP_ARG_MAP: skip_step({31'd0, n, 1'b0});
         default: begin
            if (n == 22) skip_step(0);
            else settle(cmkp_pkg::VERDICT_MALFORMED);
         end
      endcase
   endfunction

   function automatic void item_head(logic [7:0] b, logic [3:0] ctx);
      logic [2:0] major;
      logic [4:0] ai;
      logic [3:0] kind;
      major = b[7:5];
      ai = b[4:0];
      if (ai >= 27) begin settle(cmkp_pkg::VERDICT_MALFORMED); return; end
      if (ctx == PH_TOP_HDR) begin
         if (major != cmkp_pkg::MAJ_MAP) begin
            settle(cmkp_pkg::VERDICT_MALFORMED); return;
         end
         kind = PH_TOP_ARG;
      end else if (ctx == PH_KEY_HDR) begin
         if (major != cmkp_pkg::MAJ_TSTR) begin
            settle(cmkp_pkg::VERDICT_MALFORMED); return;
         end
         kind = PH_KEY_ARG;
      end else if (ctx == PH_CERT_HDR) begin
         if (major != cmkp_pkg::MAJ_BSTR) begin
            settle(cmkp_pkg::VERDICT_MALFORMED); return;
         end
         kind = PH_CERT_ARG;
      end else begin
         if (major == cmkp_pkg::MAJ_UINT || major == cmkp_pkg::MAJ_NINT) begin
            if (ai < 24) skip_step(0);
            else begin acc = 32'd1 << (ai - 24); ph = PH_SKIP_STR; end
            return;
         end
         if (major == cmkp_pkg::MAJ_BSTR || major == cmkp_pkg::MAJ_TSTR)
            kind = PH_SKIP_ARG_STR;
         else if (major == cmkp_pkg::MAJ_MAP) kind = PH_SKIP_ARG_MAP;
         else if (major == cmkp_pkg::MAJ_SIMPLE) kind = PH_SKIP_ARG_SIMPLE;
         else begin settle(cmkp_pkg::VERDICT_MALFORMED); return; end
      end
      if (ai < 24) arg_done(kind, {27'd0, ai});
      else begin
         argn = 3'(1 << (ai - 24)); acc = 0; ph = kind;
      end
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      case (ph)
         PH_START: begin
            if (b == cmkp_pkg::TAG_BYTE0) ph = PH_PRE1;
            else item_head(b, PH_TOP_HDR);
         end
         PH_PRE1: begin
            argn = (b == cmkp_pkg::TAG_BYTE0) ? 3'd0 : 3'd1;
            ph = PH_PRE2;
         end
         PH_PRE2: begin
            if (argn == 0 && b == cmkp_pkg::TAG_BYTE2) ph = PH_TOP_HDR;
            else settle(cmkp_pkg::VERDICT_MALFORMED);
            argn = 0;
         end
         PH_TOP_HDR, PH_KEY_HDR, PH_CERT_HDR, PH_SKIP_HDR: item_head(b, ph);
         PH_TOP_ARG, PH_KEY_ARG, PH_CERT_ARG, PH_SKIP_ARG_STR, PH_SKIP_ARG_MAP,
         PH_SKIP_ARG_SIMPLE: begin
            acc = {acc[23:0], b};
            if (argn > 0) argn--;
            if (argn == 0) arg_done(ph, acc);
         end
         PH_KEY_TXT: begin
            if (kpos >= 11 || b != cert_char(kpos)) kmatch = 1'b0;
            if (kpos < 11) kpos++;
            acc--;
            if (acc == 0) key_end();
         end
         PH_CERT_BODY: begin
            acc--;
            if (acc == 0) settle(cmkp_pkg::VERDICT_FOUND);
         end
         default: begin
            acc--;
            if (acc == 0) skip_step(0);
         end
      endcase
   endfunction

   function automatic void predict_word(byte_word_t w);
      verdict_word_t r;
      if (!decided) parse_byte(w.data);
      if (w.last) begin
         r.verdict = decided ? dec : cmkp_pkg::VERDICT_TRUNCATED;
         r.present = (r.verdict == cmkp_pkg::VERDICT_FOUND);
         expected_verdicts.push_back(r);
         pred_clear();
      end
   endfunction

   // ---------------- buffer construction ----------------
   byte_word_t buf_q[$];

   function automatic void put(logic [7:0] b);
      byte_word_t w;
      w.data = b; w.last = 1'b0;
      buf_q.push_back(w);
   endfunction

   // header with argument n, choosing a random (possibly non-minimal) width
   function automatic void put_head(logic [2:0] major, int unsigned n);
      int form;
      form = (n < 24) ? $urandom_range(0, 4) : (n < 256 ? $urandom_range(1, 4)
             : (n < 65536 ? $urandom_range(2, 4) : 3));
      if (form == 0) put({major, 5'(n)});
      else if (form == 1) begin put({major, 5'd24}); put(8'(n)); end
      else if (form == 2) begin put({major, 5'd25}); put(8'(n >> 8)); put(8'(n)); end
      else if (form == 3) begin
         put({major, 5'd26});
         put(8'(n >> 24)); put(8'(n >> 16)); put(8'(n >> 8)); put(8'(n));
      end else begin
         put({major, 5'd27});
         for (int i = 0; i < 8; i++) put(i < 4 ? 8'h00 : 8'(n >> (8 * (7 - i))));
      end
   endfunction

   function automatic void put_str(logic [2:0] major, int unsigned len);
      put_head(major, len);
      for (int i = 0; i < len; i++) put(8'($urandom));
   endfunction

   function automatic void put_key();
      int k;
      k = $urandom_range(0, 5);
      if (k < 3) begin
         put_head(cmkp_pkg::MAJ_TSTR, 11);
         for (int i = 0; i < 11; i++) put(cert_char(i));
      end else if (k == 3) begin
         put_head(cmkp_pkg::MAJ_TSTR, 11);
         for (int i = 0; i < 11; i++)
            put(i == 10 ? 8'($urandom) : cert_char(i));
      end else put_str(cmkp_pkg::MAJ_TSTR, $urandom_range(0, 13));
   endfunction

   function automatic void put_value(int depth);
      int k, n;
      k = $urandom_range(0, 9);
      case (k)
         0: put_head(cmkp_pkg::MAJ_UINT, $urandom_range(0, 300));
         1: put_head(cmkp_pkg::MAJ_NINT, $urandom);
         2: put_str(cmkp_pkg::MAJ_BSTR, $urandom_range(0, 6));
         3: put_str(cmkp_pkg::MAJ_TSTR, $urandom_range(0, 6));
         4: put(8'hF6);
         5: put(8'hF8 - 8'd2 + 8'(($urandom_range(0, 1)) * 2)); // F6 or F8
         6, 7: begin
            n = (depth < 20) ? $urandom_range(0, 2) : 0;
            put_head(cmkp_pkg::MAJ_MAP, n);
            for (int i = 0; i < 2 * n; i++) put_value(depth + 1);
         end
         8: put_head(cmkp_pkg::MAJ_SIMPLE, 22);
         default: put(8'($urandom));
      endcase
   endfunction

   function automatic void put_deep(int d);
      for (int i = 0; i < d; i++) begin
         put(8'hA2); put(8'h00);
      end
      put(8'h00);
      for (int i = 0; i < d; i++) put(8'h00);
   endfunction

   function automatic void close_buf();
      buf_q[$].last = 1'b1;
      foreach (buf_q[i]) pending_bytes.push_back(buf_q[i]);
      buf_q.delete();
   endfunction

   function automatic void random_buffer();
      int pairs_n, cut, k, n;
      byte_word_t w;
      k = $urandom_range(0, 9);
      if ($urandom_range(0, 1)) begin put(8'hD9); put(8'hD9); put(8'hF7); end
      if (k == 0) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) put(8'($urandom));
      end else begin
         pairs_n = $urandom_range(1, 4);
         put_head(cmkp_pkg::MAJ_MAP, pairs_n);
         for (int i = 0; i < pairs_n; i++) begin
            put_key();
            if ($urandom_range(0, 2) == 0)
               put_str(cmkp_pkg::MAJ_BSTR, $urandom_range(0, 5));
            else if ($urandom_range(0, 7) == 0) put_deep($urandom_range(14, 18));
            else put_value(0);
         end
      end
      if (k == 1 && buf_q.size() > 1) begin
         cut = $urandom_range(1, buf_q.size() - 1);
         while (buf_q.size() > cut) w = buf_q.pop_back();
      end
      if (k == 2) put(8'($urandom));
      close_buf();
   endfunction

   task automatic directed_buffers();
      put(8'hA0); close_buf();                                    // empty map
      put(8'hD9); put(8'hD9); put(8'hF7); put(8'hA1);
      put_head(cmkp_pkg::MAJ_TSTR, 11);
      for (int i = 0; i < 11; i++) put(cert_char(i));
      put(8'h41); put(8'hFF); close_buf();                        // found
      put(8'hA1); put(8'h6B);
      for (int i = 0; i < 11; i++) put(cert_char(i));
      put(8'h40); close_buf();                                    // empty
      put(8'hD9); put(8'h00); put(8'h01); close_buf();            // broken tag
      put(8'hD9); put(8'hD9); close_buf();                        // cut prefix
      put(8'h80); close_buf();                                    // not a map
      put(8'hBF); close_buf();                                    // ai 31
      put(8'hA1); put(8'h01); close_buf();                        // key not text
      put(8'hA1); put(8'h60); put(8'h80); close_buf();            // major 4 skip
      put(8'hA1); put(8'h60); put(8'hC0); close_buf();            // major 6 skip
      put(8'hA1); put(8'h60); put(8'hF5); close_buf();            // simple not 22
      put(8'hA1); put(8'h60); put(8'hF8); put(8'h16); close_buf(); // simple 22 wide
      put(8'hBA); put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF); close_buf();
      put(8'hA1); put(8'h60); put(8'h5B);
      for (int i = 0; i < 8; i++) put(8'hFF);
      close_buf();                                                // saturated length
      put(8'hA1); put(8'h60); put_deep(16); close_buf();          // nesting fills the stack to its full depth
      put(8'hA1); put(8'h60); put_deep(15); close_buf();
      put(8'hA1); put(8'h6B);
      for (int i = 0; i < 11; i++) put(cert_char(i));
      put(8'h60); close_buf();                                    // cert not bstr
      put(8'hA1); put(8'h6B);
      for (int i = 0; i < 11; i++) put(cert_char(i));
      put(8'h45); put(8'h01); close_buf();                        // short body
      put(8'hFF); close_buf();
      put(8'h7F); close_buf();
   endtask

   initial begin
      directed_buffers();
      while (pending_bytes.size() < 1000) random_buffer();
   end

   // ---------------- driver ----------------
   int gap = 0;
   always @(posedge clock) begin
      byte_word_t w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            w.data = req_data_byte; w.last = req_final_byte;
            predict_word(w);
         end
         if (req_valid && !req_ready) begin
            // hold
         end else if (gap > 0) begin
            gap--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            w = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= w.data;
            req_final_byte <= w.last;
            if ($urandom_range(0, 3) == 0)
               gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
                                                  : $urandom_range(0, 2);
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // ---------------- monitor ----------------
   int rgap = 0;
   int accepted = 0;
   always @(posedge clock) begin
      verdict_word_t e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            accepted++;
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected verdict word %0d", rsp_verdict);
            end else begin
               e = expected_verdicts.pop_front();
               if (rsp_verdict !== e.verdict || rsp_field_present !== e.present) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("verdict mismatch: expected %0d/%0b got %0d/%0b",
                              e.verdict, e.present, rsp_verdict, rsp_field_present);
               end
            end
         end
         // long hold-off once, while the sender keeps offering bytes
         if (accepted == 40 && hold_off == 0) hold_off = 400;
         if (hold_off > 1) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if (rgap > 0) begin
            rgap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               rgap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(0, 2);
         end
         if (hold_off == 1 && accepted > 40) hold_off = -1;
      end
   end

   initial begin
      pred_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      wait (expected_verdicts.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
